/* rtl/core/zzv_pkg.sv */
// ----------------------------------------------------------------------------
// zzv_pkg: shared types for the zigzag varint value decoder
// Codes for value kinds and result status, decoder state and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package zzv_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned CountW   = 4;
  localparam int unsigned MaxBytes = 10;

  localparam logic [7:0] GroupMask = 8'h7f;
  localparam logic [7:0] MoreBit   = 8'h80;

  typedef enum logic [2:0] {
    KIND_LONG  = 3'd0,
    KIND_INT   = 3'd1,
    KIND_LEN   = 3'd2,
    KIND_COUNT = 3'd3,
    KIND_BOOL  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_INT_OOR  = 3'd2,
    ST_NEG_LEN  = 3'd3,
    ST_BAD_BOOL = 3'd4
  } status_e;

  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] cnt;
    kind_e             kind;
    logic              skip;
    logic [ValueW-1:0] held;
  } dec_state_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_e           status;
    kind_e             kind;
  } dec_result_t;

  // bit position of a 7-bit group: 7 * byte index
  function automatic logic [5:0] group_shift(input logic [CountW-1:0] idx);
    logic [5:0] sh;
    case (idx)
      4'd0:    sh = 6'd0;
      4'd1:    sh = 6'd7;
      4'd2:    sh = 6'd14;
      4'd3:    sh = 6'd21;
      4'd4:    sh = 6'd28;
      4'd5:    sh = 6'd35;
      4'd6:    sh = 6'd42;
      4'd7:    sh = 6'd49;
      4'd8:    sh = 6'd56;
      default: sh = 6'd63;
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/zzv_step.sv */
// ----------------------------------------------------------------------------
// zzv_step: one byte of varint decoding
// Folds a byte into the decoder state and forms the result when a value ends.
// ----------------------------------------------------------------------------
`default_nettype none

module zzv_step
  import zzv_pkg::*;
(
  input  dec_state_t  state_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  byte_i,
  output dec_state_t  state_o,
  output logic        emit_o,
  output dec_result_t result_o
);

  logic              start;
  kind_e             k_eff;
  logic [ValueW-1:0] acc_new;
  logic [ValueW-1:0] val;
  logic [CountW-1:0] cnt_new;
  logic              fits32;

  assign start   = (state_i.cnt == '0) && !state_i.skip;
  assign acc_new = state_i.acc
                 | ({{(ValueW-8){1'b0}}, byte_i & GroupMask} << group_shift(state_i.cnt));
  assign cnt_new = state_i.cnt + 4'd1;
  // zigzag: (enc >> 1) ^ -(enc & 1)
  assign val     = {1'b0, acc_new[ValueW-1:1]} ^ {ValueW{acc_new[0]}};
  // int32 fits when the top 33 bits are all equal
  assign fits32  = (&val[ValueW-1:31]) || !(|val[ValueW-1:31]);

  always_comb begin
    if (!start) begin
      k_eff = state_i.kind;
    end else if (kind_i > 3'(KIND_BOOL)) begin
      k_eff = KIND_LONG;
    end else begin
      k_eff = kind_e'(kind_i);
    end
  end

  always_comb begin
    state_o         = state_i;
    state_o.kind    = k_eff;
    emit_o          = 1'b0;
    result_o.value  = val;
    result_o.status = ST_OK;
    result_o.kind   = k_eff;

    if (start && (k_eff == KIND_BOOL)) begin
      emit_o         = 1'b1;
      result_o.value = {{(ValueW-8){1'b0}}, byte_i};
      result_o.status = (byte_i <= 8'd1) ? ST_OK : ST_BAD_BOOL;
    end else if ((byte_i & MoreBit) != 8'd0) begin
      if (cnt_new >= CountW'(MaxBytes)) begin
        emit_o          = 1'b1;
        result_o.value  = '0;
        result_o.status = ST_TOO_LONG;
        result_o.kind   = state_i.skip ? KIND_COUNT : k_eff;
        state_o.acc     = '0;
        state_o.cnt     = '0;
        state_o.skip    = 1'b0;
        state_o.held    = '0;
      end else begin
        state_o.acc = acc_new;
        state_o.cnt = cnt_new;
      end
    end else begin
      state_o.acc = '0;
      state_o.cnt = '0;
      if (state_i.skip) begin
        // size varint after a negative count is dropped
        emit_o         = 1'b1;
        result_o.value = state_i.held;
        result_o.kind  = KIND_COUNT;
        state_o.skip   = 1'b0;
        state_o.held   = '0;
      end else begin
        unique case (k_eff)
          KIND_INT, KIND_LEN: begin
            emit_o = 1'b1;
            if (!fits32) begin
              result_o.status = ST_INT_OOR;
            end else if ((k_eff == KIND_LEN) && val[ValueW-1]) begin
              result_o.status = ST_NEG_LEN;
            end
          end
          KIND_COUNT: begin
            if (val[ValueW-1]) begin
              state_o.held = '0 - val;
              state_o.skip = 1'b1;
            end else begin
              emit_o = 1'b1;
            end
          end
          default: begin
            emit_o        = 1'b1;
            result_o.kind = KIND_LONG;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/zigzag_varint_value_decoder_unit.sv */
// ----------------------------------------------------------------------------
// zigzag_varint_value_decoder_unit: streaming zigzag varint decoder
// Decodes base-128 little-endian varints into typed signed 64-bit values.
// ----------------------------------------------------------------------------
// Usage
//   Slave side: one encoded byte per beat in s_axis_tdata; s_axis_tuser carries
//   the value kind (0 long, 1 int, 2 length, 3 item count, 4 bool), sampled
//   only on the first byte of a value.
//   Master side: one beat per finished value or error: value and status in
//   m_axis_tdata, the reported kind in m_axis_tuser. Bytes in the middle of a
//   varint, and a negative item count waiting for its size varint, give no beat.
// Timing
//   A byte lands in an input register, is decoded from there and its result,
//   if any, is registered in the output register.
//   One byte per cycle while the output is not stalled; the per-byte step is a
//   64-bit shift-OR, zigzag map and range check, closed between the two registers.
// Reset
//   rst_ni clears both valid flags and the decoder state (accumulator, byte
//   count, kind, pending count); the first byte after reset starts a value.
// Stalls
//   While m_axis_tready is low the output holds; one more byte is taken into an
//   empty input register, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module zigzag_varint_value_decoder_unit
  import zzv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] value, [66:64] status, [71:67] zero
  output logic [2:0]  m_axis_tuser    // [2:0] value_kind
);

  // input register
  logic        in_valid_q;
  logic [2:0]  in_kind_q;
  logic [7:0]  in_byte_q;

  // decoder state and result register
  dec_state_t  state_q, state_d;
  logic        out_valid_q;
  dec_result_t out_q;

  logic        emit;
  dec_result_t result;
  logic        advance;

  // the held byte moves on when the output register is free or drains now
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  zzv_step u_step (
    .state_i  (state_q),
    .kind_i   (in_kind_q),
    .byte_i   (in_byte_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.status, out_q.value};
  assign m_axis_tuser  = out_q.kind;

endmodule

`default_nettype wire

/* rtl/core/zzv_checker.sv */
// ----------------------------------------------------------------------------
// zzv_checker: port-level checks for the zigzag varint decoder
// Result consistency between status, kind and value on the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module zzv_checker
  import zzv_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic [71:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic [63:0] value;
  logic [2:0]  status;

  assign value  = m_axis_tdata[63:0];
  assign status = m_axis_tdata[66:64];

  // valid flag is cleared asynchronously by reset, so no beat may follow a sampled reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result beat during reset");

  a_too_long_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == 3'(ST_TOO_LONG))) |-> (value == 64'd0))
    else $error("overlong varint must report zero");

  a_bool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == 3'(KIND_BOOL))) |->
      (value[63:8] == 56'd0) &&
      ((status == 3'(ST_OK)) == (value[7:0] <= 8'd1)))
    else $error("bool result inconsistent");

  a_neg_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == 3'(ST_NEG_LEN))) |->
      ((m_axis_tuser == 3'(KIND_LEN)) && value[63]))
    else $error("negative length status on wrong kind or value");

  a_int_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == 3'(ST_INT_OOR))) |->
      (((m_axis_tuser == 3'(KIND_INT)) || (m_axis_tuser == 3'(KIND_LEN))) &&
       !(&value[63:31]) && (|value[63:31])))
    else $error("int range status on in-range value");

endmodule

bind zigzag_varint_value_decoder_unit zzv_checker u_zzv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
